### rtl/shd_pkg.sv
// ----------------------------------------------------------------------------
// shd_pkg
// Shared widths, tap table, memory port types and the output rounding
// function of the stereo halfband decimator.
// ----------------------------------------------------------------------------
package shd_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int SUM_W      = SAMPLE_W + 16;
   localparam int COEF_W     = 14;
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int COEF_SHIFT = 14;
   localparam int CENTRE_SHIFT = 13;
   localparam int TAP_COUNT  = 9;
   localparam int IDX_W      = $clog2(TAP_COUNT);
   localparam int STEP_W     = $clog2(TAP_COUNT + 1);
   localparam int SHIFT_W    = SUM_W + 1 - COEF_SHIFT;

   localparam logic [STEP_W-1:0] OUT_STEP    = STEP_W'(0);
   localparam logic [STEP_W-1:0] CENTRE_STEP = STEP_W'(5);
   localparam logic [STEP_W-1:0] LAST_STEP   = STEP_W'(TAP_COUNT);

   // one coefficient per step: output tap, then r8 down to r0
   localparam logic signed [COEF_W-1:0] TAP_COEF [TAP_COUNT+1] = '{
      14'sd18, -14'sd116, 14'sd429, -14'sd1277, 14'sd5042,
      14'sd5042, -14'sd1277, 14'sd429, -14'sd116, 14'sd18
   };

   localparam logic signed [SUM_W:0] ROUND_BIAS = (SUM_W+1)'(2 ** (COEF_SHIFT - 1));
   localparam logic signed [SHIFT_W-1:0] SAT_HI = SHIFT_W'(2 ** (SAMPLE_W - 1) - 1);
   localparam logic signed [SHIFT_W-1:0] SAT_LO = ~SAT_HI;

   typedef struct packed {
      logic             en;
      logic             ch;
      logic [IDX_W-1:0] idx;
   } psum_rd_type;

   typedef struct packed {
      logic                    en;
      logic                    ch;
      logic [IDX_W-1:0]        idx;
      logic signed [SUM_W-1:0] data;
   } psum_wr_type;

   function automatic logic signed [SAMPLE_W-1:0] round_sat(
      input logic signed [SUM_W-1:0] acc
   );
      logic signed [SUM_W:0]     biased;
      logic signed [SHIFT_W-1:0] shifted;
      logic signed [SHIFT_W-1:0] clipped;
      biased  = (SUM_W+1)'(acc) + ROUND_BIAS;
      shifted = signed'(biased[SUM_W:COEF_SHIFT]);
      if (shifted > SAT_HI) begin
         clipped = SAT_HI;
      end else if (shifted < SAT_LO) begin
         clipped = SAT_LO;
      end else begin
         clipped = shifted;
      end
      return clipped[SAMPLE_W-1:0];
   endfunction

endpackage

### rtl/shd_if.sv
// ----------------------------------------------------------------------------
// shd_if
// Valid/ready stream interfaces for frame pairs in and decimated frames out.
// ----------------------------------------------------------------------------
interface shd_req_if import shd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_even;
   logic signed [SAMPLE_W-1:0] right_even;
   logic signed [SAMPLE_W-1:0] left_odd;
   logic signed [SAMPLE_W-1:0] right_odd;

   modport source (output valid, left_even, right_even, left_odd, right_odd, input ready);
   modport sink   (input valid, left_even, right_even, left_odd, right_odd, output ready);
endinterface

interface shd_rsp_if import shd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_left;
   logic signed [SAMPLE_W-1:0] out_right;

   modport source (output valid, out_left, out_right, input ready);
   modport sink   (input valid, out_left, out_right, output ready);
endinterface

### rtl/shd_psum_mem.sv
// ----------------------------------------------------------------------------
// shd_psum_mem
// Partial sum store, two channels by nine entries, one read and one write
// port, registered read; entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module shd_psum_mem import shd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  psum_rd_type             rd_req,
   output logic signed [SUM_W-1:0] rd_data,
   input  psum_wr_type             wr_req
);

   logic signed [SUM_W-1:0] mem_ff [2][TAP_COUNT];
   logic                    written_ff [2][TAP_COUNT];
   logic signed [SUM_W-1:0] rd_data_ff;
   logic                    rd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem_ff[wr_req.ch][wr_req.idx] <= wr_req.data;
      end
      if (rd_req.en) begin
         rd_data_ff <= mem_ff[rd_req.ch][rd_req.idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < TAP_COUNT; i++) begin
               written_ff[c][i] <= 1'b0;
            end
         end
         rd_hit_ff <= 1'b0;
      end else begin
         if (wr_req.en) begin
            written_ff[wr_req.ch][wr_req.idx] <= 1'b1;
         end
         if (rd_req.en) begin
            rd_hit_ff <= written_ff[rd_req.ch][rd_req.idx];
         end
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule

### rtl/stereo_halfband_decimator_unit.sv
// Each word passes the holding register, a left and a right sequencer pass, the add
// and finish stages and the output register; the single shared multiplier forms ten
// products per channel, one per cycle, while partial sums stream through the memory.
// A word is taken into a holding register while the previous one is still in work.
// Reset (synchronous) clears the sequencer, the handshakes and the partial-sum
// valid bits, so the filter restarts from zero state at once, with no clearing pass.
// ----------------------------------------------------------------------------
// stereo_halfband_decimator_unit
// 19-tap halfband decimate-by-two for stereo words, transposed polyphase form,
// partial sums held in a read-modify-write memory.
// ----------------------------------------------------------------------------
module stereo_halfband_decimator_unit import shd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   shd_req_if.sink   req_port,
   shd_rsp_if.source rsp_port
);

   // input holding register
   logic                       buf_valid_ff, buf_valid_in;
   logic signed [SAMPLE_W-1:0] buf_le_ff, buf_re_ff, buf_lo_ff, buf_ro_ff;

   // current word
   logic signed [SAMPLE_W-1:0] cur_le_ff, cur_re_ff, cur_lo_ff, cur_ro_ff;

   // sequencer
   logic              active_ff, active_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              ch_ff, ch_in;
   logic              last_issue, out_free, load;

   // issue stage
   logic signed [SAMPLE_W-1:0] x0, x1;
   psum_rd_type                rd_req;
   psum_wr_type                wr_req;
   logic signed [SUM_W-1:0]    rd_data;

   // add stage
   logic                       b_valid_ff;
   logic [STEP_W-1:0]          b_step_ff;
   logic                       b_ch_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [SUM_W-1:0]    centre_ff, centre_in;
   logic signed [SUM_W-1:0]    base, sum_b;

   // finish stage
   logic                       c_valid_ff, c_ch_ff;
   logic signed [SUM_W-1:0]    acc_ff;
   logic signed [SAMPLE_W-1:0] fin;
   logic signed [SAMPLE_W-1:0] left_hold_ff;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_left_ff, rsp_right_ff;

   assign req_port.ready = !buf_valid_ff;
   assign last_issue     = active_ff && ch_ff && (step_ff == LAST_STEP);
   // the previous result is already in the output register when a word starts
   assign out_free       = !rsp_valid_ff || rsp_port.ready;
   assign load           = buf_valid_ff && out_free && (!active_ff || last_issue);

   always_comb begin
      buf_valid_in = buf_valid_ff;
      if (load) begin
         buf_valid_in = 1'b0;
      end
      if (req_port.valid && req_port.ready) begin
         buf_valid_in = 1'b1;
      end
   end

   always_comb begin
      active_in = active_ff;
      step_in   = step_ff;
      ch_in     = ch_ff;
      if (load) begin
         active_in = 1'b1;
         step_in   = OUT_STEP;
         ch_in     = 1'b0;
      end else if (active_ff) begin
         if (step_ff == LAST_STEP) begin
            step_in = OUT_STEP;
            if (ch_ff) begin
               active_in = 1'b0;
            end else begin
               ch_in = 1'b1;
            end
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   assign x0 = ch_ff ? cur_re_ff : cur_le_ff;
   assign x1 = ch_ff ? cur_ro_ff : cur_lo_ff;

   // step s reads r[8-s]; the last step starts a fresh r0 from zero
   always_comb begin
      rd_req.en  = active_ff && (step_ff != LAST_STEP);
      rd_req.ch  = ch_ff;
      rd_req.idx = IDX_W'(TAP_COUNT - 1) - IDX_W'(step_ff);
   end

   assign prod_in   = PROD_W'(x0) * PROD_W'(TAP_COEF[step_ff]);
   assign centre_in = (step_ff == CENTRE_STEP) ? (SUM_W'(x1) <<< CENTRE_SHIFT) : '0;

   assign base  = (b_step_ff == LAST_STEP) ? '0 : rd_data;
   assign sum_b = base + SUM_W'(prod_ff) + centre_ff;

   // step s writes r[9-s]; step zero is the output tap
   always_comb begin
      wr_req.en   = b_valid_ff && (b_step_ff != OUT_STEP);
      wr_req.ch   = b_ch_ff;
      wr_req.idx  = IDX_W'(TAP_COUNT) - IDX_W'(b_step_ff);
      wr_req.data = sum_b;
   end

   shd_psum_mem u_psum_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_req  (rd_req),
      .rd_data (rd_data),
      .wr_req  (wr_req)
   );

   assign fin = round_sat(acc_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (c_valid_ff && c_ch_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         step_ff      <= OUT_STEP;
         ch_ff        <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         active_ff    <= active_in;
         step_ff      <= step_in;
         ch_ff        <= ch_in;
         b_valid_ff   <= active_ff;
         c_valid_ff   <= b_valid_ff && (b_step_ff == OUT_STEP);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         buf_le_ff <= req_port.left_even;
         buf_re_ff <= req_port.right_even;
         buf_lo_ff <= req_port.left_odd;
         buf_ro_ff <= req_port.right_odd;
      end
      if (load) begin
         cur_le_ff <= buf_le_ff;
         cur_re_ff <= buf_re_ff;
         cur_lo_ff <= buf_lo_ff;
         cur_ro_ff <= buf_ro_ff;
      end
      b_step_ff <= step_ff;
      b_ch_ff   <= ch_ff;
      prod_ff   <= prod_in;
      centre_ff <= centre_in;
      c_ch_ff   <= b_ch_ff;
      acc_ff    <= sum_b;
      if (c_valid_ff && !c_ch_ff) begin
         left_hold_ff <= fin;
      end
      if (c_valid_ff && c_ch_ff) begin
         rsp_left_ff  <= left_hold_ff;
         rsp_right_ff <= fin;
      end
   end

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.out_left  = rsp_left_ff;
   assign rsp_port.out_right = rsp_right_ff;

`ifndef SYNTHESIS
   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      !(rd_req.en && wr_req.en && (rd_req.ch == wr_req.ch) && (rd_req.idx == wr_req.idx)))
      else $error("partial sum read and write hit the same entry");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && c_ch_ff) |-> !rsp_valid_ff)
      else $error("result word overwritten before it was taken");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (step_ff <= LAST_STEP))
      else $error("sequencer step out of range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(c_valid_ff && c_ch_ff))
      else $error("result word raised without a finished right channel");

   a_one_output_per_pass: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && !c_ch_ff) |=> !c_valid_ff)
      else $error("two output taps in consecutive cycles");
`endif

endmodule

### sim/stereo_halfband_decimator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_halfband_decimator_unit_test
// Drives frame pairs into the decimator and checks every decimated frame
// against a bit-exact model of the 19-tap polyphase filter kept in the bench.
// Covers full-scale extremes, overshoot into saturation, the round-half-up
// case, random traffic with idle gaps on both sides, and output backpressure.
// ----------------------------------------------------------------------------
module stereo_halfband_decimator_unit_test;
   import shd_pkg::*;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct {
      sample_type left;
      sample_type right;
   } frame_type;

   localparam longint TAP_H0 = 8192;
   localparam longint TAP_H1 = 5042;
   localparam longint TAP_H3 = -1277;
   localparam longint TAP_H5 = 429;
   localparam longint TAP_H7 = -116;
   localparam longint TAP_H9 = 18;
   localparam longint ROUND_HALF = 64'sd1 <<< (COEF_SHIFT - 1);
   localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_MIN = -(64'sd1 <<< (SAMPLE_W - 1));

   localparam int LEFT  = 0;
   localparam int RIGHT = 1;

   localparam int RESET_CYCLES     = 9;
   localparam int LONG_HOLD_CYCLES = 500;
   localparam int SETTLE_CYCLES    = 40;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int REPORT_LIMIT     = 10;

   logic clock;
   logic reset;

   shd_req_if req_bus ();
   shd_rsp_if rsp_bus ();

   stereo_halfband_decimator_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // partial sums r0..r8 per channel, in units of 2^-14 of an input lsb
   longint chan_sums [2][9];
   frame_type pending_frames [$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  req_idle_max   = 8;
   int  rsp_idle_max   = 8;
   int  stall_left     = 0;
   int  rsp_gap;
   bit  long_hold_req  = 1'b0;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // one channel of the transposed polyphase filter, returns the rounded, saturated output
   function automatic sample_type push_channel(int ch, longint x0, longint x1);
      longint p9, p7, p5, p3, p1, acc, y;
      p9 = TAP_H9 * x0;
      p7 = TAP_H7 * x0;
      p5 = TAP_H5 * x0;
      p3 = TAP_H3 * x0;
      p1 = TAP_H1 * x0;
      acc = chan_sums[ch][8] + p9;
      chan_sums[ch][8] = chan_sums[ch][7] + p7;
      chan_sums[ch][7] = chan_sums[ch][6] + p5;
      chan_sums[ch][6] = chan_sums[ch][5] + p3;
      chan_sums[ch][5] = chan_sums[ch][4] + p1;
      chan_sums[ch][4] = chan_sums[ch][3] + p1 + TAP_H0 * x1;
      chan_sums[ch][3] = chan_sums[ch][2] + p3;
      chan_sums[ch][2] = chan_sums[ch][1] + p5;
      chan_sums[ch][1] = chan_sums[ch][0] + p7;
      chan_sums[ch][0] = p9;
      y = (acc + ROUND_HALF) >>> COEF_SHIFT;
      if (y > SAMPLE_MAX) begin
         y = SAMPLE_MAX;
      end else if (y < SAMPLE_MIN) begin
         y = SAMPLE_MIN;
      end
      return sample_type'(y);
   endfunction

   function automatic frame_type decimate_pair(sample_type le, sample_type re,
                                               sample_type lo, sample_type ro);
      frame_type f;
      f.left  = push_channel(LEFT, longint'(le), longint'(lo));
      f.right = push_channel(RIGHT, longint'(re), longint'(ro));
      return f;
   endfunction

   function automatic sample_type rand_sample();
      case ($urandom_range(0, 9))
         0: return sample_type'(SAMPLE_MAX);
         1: return sample_type'(SAMPLE_MIN);
         2: return sample_type'(int'($urandom_range(0, 128)) - 64);
         default: return sample_type'($urandom());
      endcase
   endfunction

   task automatic report_field(string name, sample_type want, sample_type got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch %s: expected %0d, got %0d", name, want, got);
         end
      end
   endtask

   task automatic check_frame(sample_type got_left, sample_type got_right);
      frame_type want;
      if (pending_frames.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("unexpected word: left %0d, right %0d", got_left, got_right);
         end
      end else begin
         want = pending_frames.pop_front();
         report_field("out_left", want.left, got_left);
         report_field("out_right", want.right, got_right);
      end
   endtask

   // result side: check each word, then stall a random number of cycles
   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
         check_frame(rsp_bus.out_left, rsp_bus.out_right);
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= 0;
      end else if (long_hold_req) begin
         long_hold_req <= 1'b0;
         rsp_bus.ready <= 1'b0;
         stall_left    <= LONG_HOLD_CYCLES;
      end else if (!rsp_bus.ready) begin
         if (stall_left > 1) begin
            stall_left <= stall_left - 1;
         end else begin
            stall_left    <= 0;
            rsp_bus.ready <= 1'b1;
         end
      end else if (rsp_bus.valid) begin
         rsp_gap = $urandom_range(0, rsp_idle_max);
         if (rsp_gap != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= rsp_gap;
         end
      end
   end

   // valid stays high across back-to-back words; it only drops for a gap or a drain
   task automatic send_pair(sample_type le, sample_type re, sample_type lo, sample_type ro);
      int gap;
      gap = $urandom_range(0, req_idle_max);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.left_even  <= le;
      req_bus.right_even <= re;
      req_bus.left_odd   <= lo;
      req_bus.right_odd  <= ro;
      do @(posedge clock); while (!req_bus.ready);
      pending_frames.push_back(decimate_pair(le, re, lo, ro));
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
   endtask

   // first-phase samples follow the tap signs, so every product adds up
   // to about 1.34 of full scale; flip puts the left channel low instead
   task automatic overshoot_burst(bit flip);
      int tap_sign [10] = '{1, -1, 1, -1, 1, 1, -1, 1, -1, 1};
      sample_type hi, lo;
      hi = sample_type'(SAMPLE_MAX);
      lo = sample_type'(SAMPLE_MIN);
      for (int k = 0; k < 10; k++) begin
         if ((tap_sign[k] > 0) ^ flip) begin
            send_pair(hi, lo, flip ? lo : hi, flip ? hi : lo);
         end else begin
            send_pair(lo, hi, flip ? lo : hi, flip ? hi : lo);
         end
      end
   endtask

   task automatic test_directed();
      // exact half lsb from the centre tap, zero state right after reset
      send_pair('0, '0, sample_type'(1), sample_type'(-1));
      repeat (5) send_pair('0, '0, '0, '0);
      send_pair(sample_type'(SAMPLE_MAX), sample_type'(SAMPLE_MAX),
                sample_type'(SAMPLE_MAX), sample_type'(SAMPLE_MAX));
      send_pair(sample_type'(SAMPLE_MIN), sample_type'(SAMPLE_MIN),
                sample_type'(SAMPLE_MIN), sample_type'(SAMPLE_MIN));
      send_pair(sample_type'(SAMPLE_MAX), sample_type'(SAMPLE_MIN), '0, '0);
      overshoot_burst(1'b0);
   endtask

   // a burst counts as the ten words it sends
   task automatic test_random_traffic(int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 39) == 0) begin
            overshoot_burst(1'($urandom_range(0, 1)));
            sent += 10;
         end else begin
            send_pair(rand_sample(), rand_sample(), rand_sample(), rand_sample());
            sent++;
         end
      end
   endtask

   task automatic test_no_idle(int count);
      req_idle_max = 0;
      rsp_idle_max <= 0;
      test_random_traffic(count);
      req_idle_max = 8;
      rsp_idle_max <= 8;
   endtask

   // receiver stops for a long stretch so the unit fills and stalls its input
   task automatic test_output_backpressure(int count);
      req_idle_max = 0;
      long_hold_req <= 1'b1;
      test_random_traffic(count);
      req_idle_max = 8;
      wait_for_drain();
   endtask

   task automatic test_sender_pause(int count);
      test_random_traffic(count);
      wait_for_drain();
      test_random_traffic(count);
   endtask

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.left_even  = '0;
      req_bus.right_even = '0;
      req_bus.left_odd   = '0;
      req_bus.right_odd  = '0;
      rsp_bus.ready      = 1'b0;
      foreach (chan_sums[c, i]) chan_sums[c][i] = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_traffic(300);
      test_no_idle(100);
      test_output_backpressure(40);
      test_sender_pause(20);
      test_random_traffic(220);

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_frames.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/shd_pkg.sv
rtl/shd_if.sv
rtl/shd_psum_mem.sv
rtl/stereo_halfband_decimator_unit.sv
sim/stereo_halfband_decimator_unit_test.sv
